// ----- sv/rac_pkg.sv -----
package rac_pkg;

  // CORDIC iteration count (table holds 24 entries)
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned TAB_LEN      = 24;
  localparam int unsigned IDX_W        = 5;

  localparam int unsigned AXIS_W = 14;  // axis value after divide by 4
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned XY_W   = 34;  // covers gain and sign of the rotated vector
  localparam int unsigned ANG_W  = 25;  // degrees, Q16, signed
  localparam int unsigned DEG_W  = 8;   // whole-degree magnitude 0..180
  localparam int unsigned ROLL_W = 9;

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);

  localparam logic [DEG_W-1:0] DEG_0   = DEG_W'(0);
  localparam logic [DEG_W-1:0] DEG_45  = DEG_W'(45);
  localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90);
  localparam logic [DEG_W-1:0] DEG_135 = DEG_W'(135);
  localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);

  // sideband that rides along the CORDIC stages
  typedef struct packed {
    logic             y_neg;
    logic             z_neg;
    logic             spec;      // exact answer known up front
    logic [DEG_W-1:0] spec_mag;
  } side_t;

  // atan(2^-i) in degrees, Q16, rounded
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = ANG_W'(2949120);
      5'd1:    v = ANG_W'(1740967);
      5'd2:    v = ANG_W'(919879);
      5'd3:    v = ANG_W'(466945);
      5'd4:    v = ANG_W'(234379);
      5'd5:    v = ANG_W'(117304);
      5'd6:    v = ANG_W'(58666);
      5'd7:    v = ANG_W'(29335);
      5'd8:    v = ANG_W'(14668);
      5'd9:    v = ANG_W'(7334);
      5'd10:   v = ANG_W'(3667);
      5'd11:   v = ANG_W'(1833);
      5'd12:   v = ANG_W'(917);
      5'd13:   v = ANG_W'(458);
      5'd14:   v = ANG_W'(229);
      5'd15:   v = ANG_W'(115);
      5'd16:   v = ANG_W'(57);
      5'd17:   v = ANG_W'(29);
      5'd18:   v = ANG_W'(14);
      5'd19:   v = ANG_W'(7);
      5'd20:   v = ANG_W'(4);
      5'd21:   v = ANG_W'(2);
      5'd22:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/rac_cordic.sv -----
// Vectoring CORDIC, one register stage per iteration, common stall enable.
module rac_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_vld,
  input  logic [rac_pkg::AXIS_W-1:0]          in_ax,
  input  logic [rac_pkg::AXIS_W-1:0]          in_ay,
  input  rac_pkg::side_t                      in_side,
  output logic                                out_vld,
  output logic signed [rac_pkg::ANG_W-1:0]    out_ang,
  output rac_pkg::side_t                      out_side
);

  localparam int unsigned N = rac_pkg::CORDIC_STEPS;

  logic signed [rac_pkg::XY_W-1:0]  x_r   [N];
  logic signed [rac_pkg::XY_W-1:0]  y_r   [N];
  logic signed [rac_pkg::ANG_W-1:0] ang_r [N];
  rac_pkg::side_t                   side_r[N];
  logic                             vld_r [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [rac_pkg::XY_W-1:0]  x_in, y_in, x_nxt, y_nxt;
    logic signed [rac_pkg::ANG_W-1:0] a_in, a_nxt, tab;
    rac_pkg::side_t                   s_in;
    logic                             v_in;

    if (i == 0) begin : g_first
      assign x_in = rac_pkg::XY_W'({in_ax, {rac_pkg::FRAC_W{1'b0}}});
      assign y_in = rac_pkg::XY_W'({in_ay, {rac_pkg::FRAC_W{1'b0}}});
      assign a_in = '0;
      assign s_in = in_side;
      assign v_in = in_vld;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign a_in = ang_r[i-1];
      assign s_in = side_r[i-1];
      assign v_in = vld_r[i-1];
    end

    assign tab = rac_pkg::atan_tab(rac_pkg::IDX_W'(i));

    always_comb begin
      if (!y_in[rac_pkg::XY_W-1]) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        a_nxt = a_in + tab;
      end else begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        a_nxt = a_in - tab;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        ang_r[i]  <= a_nxt;
        side_r[i] <= s_in;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_ang  = ang_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ----- sv/roll_angle_from_accel_unit.sv -----
// Channel | Dir | Ports                        | Beat contents
// --------+-----+------------------------------+---------------------------------------
// in      | in  | in_tvalid/in_tready/in_tdata | [15:0] y_word, [31:16] z_word (signed)
// out     | out | out_tvalid/out_tready/       | [8:0] roll_degrees (signed),
//         |     | out_tdata                    | [15:9] zero
//
// One beat in, one beat out. Stages: prep, one per CORDIC iteration, output.
// Throughput is one beat per cycle unless stalled; the whole pipeline advances on a single
// enable that is high when the output register is empty or being drained.
// rst_n (sync, active low) clears the valid bits only; no clearing pass.
// A stall freezes every stage in place, so nothing is dropped or repeated.
module roll_angle_from_accel_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] y_word, [31:16] z_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // [8:0] roll_degrees, [15:9] zero
);

  logic out_tvalid_r;
  logic adv;
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // ---------------- prep stage: /4 toward zero, fold, special cases
  logic signed [15:0]              y_word, z_word;
  logic signed [16:0]              y_sum, z_sum;
  logic signed [rac_pkg::AXIS_W-1:0] yv, zv;
  logic [rac_pkg::AXIS_W-1:0]      ay, az;
  rac_pkg::side_t                  side_nxt;

  assign y_word = in_tdata[15:0];
  assign z_word = in_tdata[31:16];

  // add 3 to negatives so the arithmetic shift truncates toward zero
  assign y_sum = 17'(y_word) + (y_word[15] ? 17'sd3 : 17'sd0);
  assign z_sum = 17'(z_word) + (z_word[15] ? 17'sd3 : 17'sd0);
  assign yv    = rac_pkg::AXIS_W'(y_sum >>> 2);
  assign zv    = rac_pkg::AXIS_W'(z_sum >>> 2);
  assign ay    = yv[rac_pkg::AXIS_W-1] ? rac_pkg::AXIS_W'(-yv) : yv;
  assign az    = zv[rac_pkg::AXIS_W-1] ? rac_pkg::AXIS_W'(-zv) : zv;

  always_comb begin
    side_nxt.y_neg    = yv[rac_pkg::AXIS_W-1];
    side_nxt.z_neg    = zv[rac_pkg::AXIS_W-1];
    side_nxt.spec     = 1'b1;
    side_nxt.spec_mag = rac_pkg::DEG_0;
    if (yv == '0) begin
      // on the Z axis (also both zero)
      side_nxt.spec_mag = zv[rac_pkg::AXIS_W-1] ? rac_pkg::DEG_180 : rac_pkg::DEG_0;
    end else if (zv == '0) begin
      side_nxt.spec_mag = rac_pkg::DEG_90;
    end else if (ay == az) begin
      // diagonal: exact 45 / 135, keeps truncation from dropping a degree
      side_nxt.spec_mag = zv[rac_pkg::AXIS_W-1] ? rac_pkg::DEG_135 : rac_pkg::DEG_45;
    end else begin
      side_nxt.spec = 1'b0;
    end
  end

  logic                       prep_vld_r;
  logic [rac_pkg::AXIS_W-1:0] prep_ax_r, prep_ay_r;
  rac_pkg::side_t             prep_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (adv) begin
      prep_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_ax_r   <= az;
      prep_ay_r   <= ay;
      prep_side_r <= side_nxt;
    end
  end

  // ---------------- CORDIC iterations
  logic                            cor_vld;
  logic signed [rac_pkg::ANG_W-1:0] cor_ang;
  rac_pkg::side_t                  cor_side;

  rac_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (prep_vld_r),
    .in_ax    (prep_ax_r),
    .in_ay    (prep_ay_r),
    .in_side  (prep_side_r),
    .out_vld  (cor_vld),
    .out_ang  (cor_ang),
    .out_side (cor_side)
  );

  // ---------------- output stage: clamp, quadrant map, integer part, sign
  logic signed [rac_pkg::ANG_W-1:0]  q_clamp, q_full;
  logic [rac_pkg::DEG_W-1:0]         mag;
  logic signed [rac_pkg::ROLL_W-1:0] roll_nxt;

  always_comb begin
    if (cor_ang[rac_pkg::ANG_W-1]) begin
      q_clamp = '0;
    end else if (cor_ang > rac_pkg::ANG_90) begin
      q_clamp = rac_pkg::ANG_90;
    end else begin
      q_clamp = cor_ang;
    end
    q_full = cor_side.z_neg ? (rac_pkg::ANG_180 - q_clamp) : q_clamp;
    mag    = cor_side.spec ? cor_side.spec_mag
                           : q_full[rac_pkg::FRAC_W +: rac_pkg::DEG_W];
    roll_nxt = cor_side.y_neg ? -rac_pkg::ROLL_W'(mag) : rac_pkg::ROLL_W'(mag);
  end

  logic signed [rac_pkg::ROLL_W-1:0] roll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= cor_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r <= roll_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(16 - rac_pkg::ROLL_W){1'b0}}, roll_r};

endmodule

// ----- verif/roll_angle_from_accel_unit_tb.sv -----
module roll_angle_from_accel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // pipeline depth is CORDIC_STEPS + 2; drain wait adds some margin on top
  localparam int unsigned DRAIN_CYCLES = rac_pkg::CORDIC_STEPS + 12;
  localparam int unsigned RAND_ITEMS   = 1330;
  localparam int unsigned HOLD_AT_BEAT = 400;   // receiver stalls once here
  localparam int unsigned HOLD_CYCLES  = 80;    // long enough to fill the pipe
  localparam int unsigned PAUSE_AT     = 900;   // sender drains the pipe here

  // atan(2^-i) in degrees, Q16, rounded to nearest
  localparam longint ATAN_DEG_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [15:0]                y;
    logic signed [15:0]                z;
    bit                                typed;  // roll below is the known answer
    logic signed [rac_pkg::ROLL_W-1:0] roll;
  } dir_row_t;

  // axes, diagonals, divide-by-4 truncation, full-scale words
  localparam int unsigned DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{16'sd0,       16'sd0,       1'b1, 9'sd0},     // both zero
    '{16'sd0,       16'sd400,     1'b1, 9'sd0},     // +Z axis
    '{16'sd0,       -16'sd400,    1'b1, 9'sd180},   // -Z axis
    '{16'sd400,     16'sd0,       1'b1, 9'sd90},    // +Y axis
    '{-16'sd400,    16'sd0,       1'b1, -9'sd90},   // -Y axis
    '{16'sd400,     16'sd400,     1'b1, 9'sd45},    // diagonals
    '{16'sd400,     -16'sd400,    1'b1, 9'sd135},
    '{-16'sd400,    -16'sd400,    1'b1, -9'sd135},
    '{-16'sd400,    16'sd400,     1'b1, -9'sd45},
    '{16'sd32767,   16'sd32767,   1'b1, 9'sd45},
    '{16'sh8000,    16'sh8000,    1'b1, -9'sd135},
    '{16'sd3,       -16'sd3,      1'b1, 9'sd0},     // both vanish in the divide
    '{-16'sd3,      16'sd100,     1'b1, 9'sd0},     // y truncates to zero
    '{16'sd1,       16'sh8000,    1'b1, 9'sd180},
    '{16'sh8000,    16'sd2,       1'b1, -9'sd90},
    '{16'sd32767,   -16'sd3,      1'b1, 9'sd90},
    '{-16'sd5,      -16'sd7,      1'b1, -9'sd135},  // both truncate to -1
    '{16'sd32767,   16'sh8000,    1'b0, 9'sd0},
    '{16'sh8000,    16'sd32767,   1'b0, 9'sd0},
    '{16'sd4,       16'sd32767,   1'b0, 9'sd0},
    '{-16'sd4,      16'sh8000,    1'b0, 9'sd0},
    '{16'sd32767,   16'sd4,       1'b0, 9'sd0},
    '{16'sd1234,    -16'sd5678,   1'b0, 9'sd0},
    '{16'sh5555,    16'shAAAA,    1'b0, 9'sd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;     // [15:0] y_word, [31:16] z_word
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;    // [8:0] roll_degrees, [15:9] zero

  logic signed [rac_pkg::ROLL_W-1:0] roll_q[$];  // expected angles, oldest first
  int unsigned fail_cnt   = 0;
  int unsigned sent_cnt   = 0;
  int unsigned rcvd_cnt   = 0;
  bit          hold_off   = 1'b0;       // receiver in its long stall
  bit          tx_steady  = 1'b0;       // sender stretch without gaps
  bit          rx_steady  = 1'b0;       // receiver stretch without stalls

  roll_angle_from_accel_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Roll angle in whole degrees: vectoring CORDIC on the folded magnitudes,
  // Q16 degree accumulator, exact answers on axes and diagonals.
  function automatic logic signed [rac_pkg::ROLL_W-1:0] roll_of(
    input logic signed [15:0] yw,
    input logic signed [15:0] zw
  );
    int     yv;
    int     zv;
    longint ay;
    longint az;
    longint x;
    longint y;
    longint dx;
    longint dy;
    longint ang;
    longint mag;
    yv = int'(yw) / 4;  // truncates toward zero
    zv = int'(zw) / 4;
    ay = (yv < 0) ? -longint'(yv) : longint'(yv);
    az = (zv < 0) ? -longint'(zv) : longint'(zv);
    if (yv == 0) begin
      mag = (zv < 0) ? 180 : 0;
    end else if (zv == 0) begin
      mag = 90;
    end else if (ay == az) begin
      mag = (zv > 0) ? 45 : 135;
    end else begin
      x   = az * 65536;
      y   = ay * 65536;
      ang = 0;
      for (int i = 0; i < rac_pkg::CORDIC_STEPS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x   = x + dx;
          y   = y - dy;
          ang = ang + ATAN_DEG_Q16[i];
        end else begin
          x   = x - dx;
          y   = y + dy;
          ang = ang - ATAN_DEG_Q16[i];
        end
      end
      if (ang < 0) ang = 0;
      if (ang > 90 * 65536) ang = 90 * 65536;
      if (zv < 0) ang = 180 * 65536 - ang;  // mirror into quadrant two
      mag = ang >>> 16;
    end
    if (yv < 0) mag = -mag;
    return mag[rac_pkg::ROLL_W-1:0];
  endfunction

  // Drive one sample at the falling edge, hold until taken, queue its angle,
  // then idle for a drawn gap (or until the pipe is empty when asked).
  task automatic offer_sample(input logic [15:0] yw, input logic [15:0] zw, input bit typed,
                              input logic signed [rac_pkg::ROLL_W-1:0] typed_roll,
                              input bit drain);
    int unsigned gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {zw, yw};
    do @(posedge clk); while (!in_tready);
    roll_q.push_back(typed ? typed_roll : roll_of(yw, zw));
    sent_cnt++;
    if (sent_cnt % 100 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    gap = (hold_off || tx_steady) ? 0 : $urandom_range(0, 9);
    if (drain) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      while (roll_q.size() != 0) @(negedge clk);
    end else if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Random sample, biased toward axes, diagonals and full-scale words
  task automatic draw_sample(output logic [15:0] yw, output logic [15:0] zw);
    logic [15:0] picks [9];
    int unsigned kind;
    picks = '{16'h8000, 16'h8001, 16'hFFFC, 16'hFFFF, 16'h0000,
              16'h0003, 16'h0004, 16'h7FFC, 16'h7FFF};
    kind  = $urandom_range(0, 9);
    yw    = 16'($urandom());
    zw    = 16'($urandom());
    case (kind)
      4: begin  // tiny magnitudes, often zero after the divide
        yw = 16'(int'($urandom_range(0, 63)) - 32);
        zw = 16'(int'($urandom_range(0, 63)) - 32);
      end
      5: begin  // equal magnitudes
        zw = $urandom_range(0, 1) ? yw : 16'(-yw);
      end
      6: begin  // on or near an axis
        if ($urandom_range(0, 1)) yw = 16'(int'($urandom_range(0, 6)) - 3);
        else zw = 16'(int'($urandom_range(0, 6)) - 3);
      end
      7: begin  // near a diagonal
        zw = 16'(int'(signed'(yw)) * ($urandom_range(0, 1) ? 1 : -1)
                 + int'($urandom_range(0, 16)) - 8);
      end
      8: begin  // one side much smaller
        zw = 16'(int'($urandom_range(0, 255)) - 128);
      end
      9: begin
        yw = picks[$urandom_range(0, 8)];
        zw = picks[$urandom_range(0, 8)];
      end
      default: ;
    endcase
  endtask

  // Result side: random stalls, one long hold-off, compare against the queue
  initial begin
    int unsigned w;
    logic signed [rac_pkg::ROLL_W-1:0] want;
    wait (rst_n === 1'b1);
    forever begin
      if (rcvd_cnt % 100 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      w = (rcvd_cnt == HOLD_AT_BEAT) ? HOLD_CYCLES : (rx_steady ? 0 : $urandom_range(0, 9));
      if (w != 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        hold_off = (w == HOLD_CYCLES);
        repeat (w - 1) @(negedge clk);
        hold_off = 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rcvd_cnt++;
      if (roll_q.size() == 0) begin
        $error("roll_degrees: no beat expected, actual %0d",
               $signed(out_tdata[rac_pkg::ROLL_W-1:0]));
        fail_cnt++;
      end else begin
        want = roll_q.pop_front();
        if (out_tdata[rac_pkg::ROLL_W-1:0] !== want) begin
          $error("roll_degrees: expected %0d, actual %0d", want,
                 $signed(out_tdata[rac_pkg::ROLL_W-1:0]));
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus: directed table, then random samples
  initial begin
    logic [15:0] yw;
    logic [15:0] zw;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TABLE[r])
      offer_sample(DIR_TABLE[r].y, DIR_TABLE[r].z, DIR_TABLE[r].typed, DIR_TABLE[r].roll,
                   1'b0);

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      draw_sample(yw, zw);
      offer_sample(yw, zw, 1'b0, '0, n == PAUSE_AT);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (roll_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);  // catch any stray beat
    if (fail_cnt == 0) begin
      $display("roll_angle_from_accel_unit regression: pass");
    end else begin
      $display("roll_angle_from_accel_unit regression: fail");
    end
    $finish;
  end

  // watchdog: reports fail and ends the run if it has not finished before this delay
  initial begin
    #2_000_000;
    $display("roll_angle_from_accel_unit regression: fail");
    $finish;
  end

endmodule
